// File: hdl/shjh_pkg.sv
// ============================================================================
// shjh_pkg
// shared widths, reset values and the half-step coil table for the stepper
// half-step sequencer
// ============================================================================
`default_nettype none

package shjh_pkg;

    localparam int POSITION_WIDTH = 32;
    localparam int PERIOD_WIDTH   = 16;
    localparam int COIL_WIDTH     = 4;
    localparam int PHASE_WIDTH    = 3;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(10);

    typedef logic [POSITION_WIDTH-1:0] position_t;
    typedef logic [PERIOD_WIDTH-1:0]   period_t;
    typedef logic [COIL_WIDTH-1:0]     coils_t;
    typedef logic [PHASE_WIDTH-1:0]    phase_t;

    localparam position_t POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    localparam position_t POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

    // bit0 A+, bit1 A-, bit2 B+, bit3 B-
    function automatic coils_t coil_pattern(input phase_t ph);
        coils_t pat;
        unique case (ph)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h5;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'hA;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// File: hdl/shjh_tick_if.sv
// ============================================================================
// shjh_tick_if
// timing tick channel carrying the three button states
// ============================================================================
`default_nettype none

interface shjh_tick_if;
    logic valid;
    logic ready;
    logic cw_pressed;
    logic ccw_pressed;
    logic home_pressed;

    modport source (output valid, output cw_pressed, output ccw_pressed,
                    output home_pressed, input ready);
    modport sink   (input valid, input cw_pressed, input ccw_pressed,
                    input home_pressed, output ready);
endinterface

`default_nettype wire

// File: hdl/shjh_result_if.sv
// ============================================================================
// shjh_result_if
// result channel: coil drive, position and status flags
// ============================================================================
`default_nettype none

interface shjh_result_if;
    logic                  valid;
    logic                  ready;
    shjh_pkg::coils_t      coils;
    shjh_pkg::position_t   position;
    logic                  homing;
    logic                  stepping;

    modport source (output valid, output coils, output position, output homing,
                    output stepping, input ready);
    modport sink   (input valid, input coils, input position, input homing,
                    input stepping, output ready);
endinterface

`default_nettype wire

// File: hdl/shjh_cfg_if.sv
// ============================================================================
// shjh_cfg_if
// configuration write channel for the step period register
// ============================================================================
`default_nettype none

interface shjh_cfg_if;
    logic              valid;
    logic              ready;
    shjh_pkg::period_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/stepper_half_step_jog_home.sv
// ============================================================================
// stepper_half_step_jog_home
// bipolar stepper half-step sequencer with jog buttons and return to origin
//
// tick   : one transaction per timing tick with the cw, ccw and home buttons
// result : one transaction per tick with coils, position, homing, stepping
// cfg    : writes the step period (ticks a step holds its coil pattern);
//          always ready, a period of 0 acts as 1
// latency: the result of a tick is offered in the cycle after its
//          transaction, from a single result register
// rate   : one tick per cycle unless stalled; the whole step decision (coil
//          table lookup, position compare and increment, hold countdown) sits
//          between the state registers and the result register
// stall  : while the result register holds an untaken result, tick is held
//          off only if result.ready is low; a taken result frees it in the
//          same cycle
// reset  : phase half-step 0, position 0, not homing, step period 10,
//          no result pending
// ============================================================================
`default_nettype none

module stepper_half_step_jog_home (
    input  wire logic        clk,
    input  wire logic        rst_n,
    shjh_tick_if.sink        tick,
    shjh_result_if.source    result,
    shjh_cfg_if.sink         cfg
);

    shjh_pkg::period_t   period_reg;
    shjh_pkg::phase_t    phase_reg;
    shjh_pkg::phase_t    phase_next;
    shjh_pkg::position_t pos_reg;
    shjh_pkg::position_t pos_next;
    logic                home_reg;
    logic                home_next;
    shjh_pkg::period_t   hold_reg;
    shjh_pkg::period_t   hold_next;

    logic                out_valid_reg;
    shjh_pkg::coils_t    coils_reg;
    shjh_pkg::coils_t    coils_next;
    logic                stepping_reg;
    logic                stepping_next;

    logic                accept;
    logic                idle;
    logic                pos_zero;
    logic                start;
    logic                start_cw;
    shjh_pkg::period_t   load_period;

    assign cfg.ready   = 1'b1;
    assign tick.ready  = !out_valid_reg || result.ready;
    assign accept      = tick.valid && tick.ready;

    assign idle        = (hold_reg == '0);
    assign pos_zero    = (pos_reg == '0);
    assign load_period = (period_reg == '0) ? shjh_pkg::period_t'(1) : period_reg;

    // step decision
    always_comb
    begin
        start     = 1'b0;
        start_cw  = 1'b0;
        home_next = home_reg;
        if (idle)
        begin
            priority if (home_reg && !pos_zero)
            begin
                start    = 1'b1;
                start_cw = pos_reg[shjh_pkg::POSITION_WIDTH-1];
            end
            else if (tick.cw_pressed)
            begin
                home_next = 1'b0;
                start     = (pos_reg != shjh_pkg::POS_MAX);
                start_cw  = 1'b1;
            end
            else if (tick.ccw_pressed)
            begin
                home_next = 1'b0;
                start     = (pos_reg != shjh_pkg::POS_MIN);
                start_cw  = 1'b0;
            end
            else if (tick.home_pressed && !pos_zero)
            begin
                home_next = 1'b1;
                start     = 1'b1;
                start_cw  = pos_reg[shjh_pkg::POSITION_WIDTH-1];
            end
            else
            begin
                home_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hold_next  = hold_reg;
        if (start)
        begin
            if (start_cw)
            begin
                phase_next = phase_reg + shjh_pkg::phase_t'(1);
                pos_next   = pos_reg + shjh_pkg::position_t'(1);
            end
            else
            begin
                phase_next = phase_reg - shjh_pkg::phase_t'(1);
                pos_next   = pos_reg - shjh_pkg::position_t'(1);
            end
            hold_next = load_period - shjh_pkg::period_t'(1);
        end
        else if (!idle)
        begin
            hold_next = hold_reg - shjh_pkg::period_t'(1);
        end
        stepping_next = start || !idle;
        coils_next    = stepping_next ? shjh_pkg::coil_pattern(phase_next) : '0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= shjh_pkg::PERIOD_RESET;
            phase_reg     <= '0;
            pos_reg       <= '0;
            home_reg      <= 1'b0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                period_reg <= cfg.data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                home_reg  <= home_next;
                hold_reg  <= hold_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coils_reg    <= coils_next;
            stepping_reg <= stepping_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.coils    = coils_reg;
    assign result.position = pos_reg;
    assign result.homing   = home_reg;
    assign result.stepping = stepping_reg;

endmodule

`default_nettype wire
